// ===== rtl/core/bsh_pkg.sv =====
// Shared types, constants and helper functions for the bilayer splay histogram unit
`timescale 1ns / 1ps
package bsh_pkg;

  localparam int POS_W   = 25;
  localparam int DIFF_W  = 26;
  localparam int ORI_W   = 18;
  localparam int SPL_W   = 19;
  localparam int SQ_W    = 52;
  localparam int ROOT_W  = 27;
  localparam int DIST_W  = 24;
  localparam int DIV_W   = 50;
  localparam int KQ_W    = 27;
  localparam int PROD_W  = 52;
  localparam int FRAC    = 16;
  localparam int CNT_W   = 32;
  localparam int BIN_W   = 8;
  localparam int CFG_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int ONE_Q16 = 65536;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [ORI_W-1:0]  ori_t;
  typedef logic signed [DIV_W-1:0]  div_t;
  typedef logic [DIV_W-1:0]         udiv_t;
  typedef logic [1:0]               axis_t;
  typedef logic [1:0]               op_t;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  localparam op_t OP_MOLECULE = 2'd0;
  localparam op_t OP_READ_BIN = 2'd1;
  localparam op_t OP_CLEAR    = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_BIN   = 1'b1;

  typedef enum logic [2:0] {
    REG_NORMAL_AXIS,
    REG_MAX_DIST,
    REG_TILT,
    REG_BIN_WIDTH,
    REG_HALF_BINS,
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  normal_axis;
    logic [23:0] max_pair_distance;
    logic [16:0] tilt_threshold;
    logic [23:0] bin_width;
    logic [6:0]  half_bins;
    logic [23:0] box_x;
    logic [23:0] box_y;
    logic [23:0] box_z;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             frame_end;
    pos_t             head_x;
    pos_t             head_y;
    pos_t             head_z;
    pos_t             tail_x;
    pos_t             tail_y;
    pos_t             tail_z;
    logic [BIN_W-1:0] bin_index;
  } in_item_t;

  typedef struct packed {
    pos_t hx;
    pos_t hy;
    pos_t hz;
    ori_t ox;
    ori_t oy;
    ori_t oz;
  } mol_rec_t;

  function automatic pos_t pick_h(mol_rec_t rec, axis_t ax);
    unique case (ax)
      AX_X:    return rec.hx;
      AX_Y:    return rec.hy;
      default: return rec.hz;
    endcase
  endfunction

  function automatic ori_t pick_o(mol_rec_t rec, axis_t ax);
    unique case (ax)
      AX_X:    return rec.ox;
      AX_Y:    return rec.oy;
      default: return rec.oz;
    endcase
  endfunction

  function automatic logic [23:0] pick_box(cfg_t cfg, axis_t ax);
    unique case (ax)
      AX_X:    return cfg.box_x;
      AX_Y:    return cfg.box_y;
      default: return cfg.box_z;
    endcase
  endfunction

  function automatic axis_t next_axis(axis_t ax);
    unique case (ax)
      AX_X:    return AX_Y;
      AX_Y:    return AX_Z;
      default: return AX_X;
    endcase
  endfunction

  function automatic logic [ORI_W-1:0] abs_ori(ori_t v);
    return v[ORI_W-1] ? ORI_W'($unsigned(-v)) : ORI_W'($unsigned(v));
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/bsh_in_if.sv =====
// Molecule and command input channel
`timescale 1ns / 1ps
interface bsh_in_if;
  import bsh_pkg::*;

  logic             valid;
  logic             ready;
  op_t              op;
  logic             frame_end;
  pos_t             head_x;
  pos_t             head_y;
  pos_t             head_z;
  pos_t             tail_x;
  pos_t             tail_y;
  pos_t             tail_z;
  logic [BIN_W-1:0] bin_index;

  modport source (
    output valid, op, frame_end, head_x, head_y, head_z, tail_x, tail_y, tail_z, bin_index,
    input  ready
  );
  modport sink (
    input  valid, op, frame_end, head_x, head_y, head_z, tail_x, tail_y, tail_z, bin_index,
    output ready
  );
endinterface

// ===== rtl/core/bsh_out_if.sv =====
// Result output channel
`timescale 1ns / 1ps
interface bsh_out_if;
  import bsh_pkg::*;

  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [CNT_W-1:0] count_value;
  logic             molecules_dropped;

  modport source (
    output valid, result_kind, count_value, molecules_dropped,
    input  ready
  );
  modport sink (
    input  valid, result_kind, count_value, molecules_dropped,
    output ready
  );
endinterface

// ===== rtl/core/bilayer_splay_histogram_unit.sv =====
// Bilayer splay histogram unit: sequencer, molecule store and histogram memory
//
// Usage: items arrive on mol_i (valid/ready). op molecule stores the head and
// the unit orientation of one molecule; with frame_end set, the pair pass runs
// over the stored frame and one frame result (kind 0, running pair total,
// dropped flag) is sent on res_o. op read bin returns one bin count (kind 1).
// op clear zeroes the histogram and gives no result. The user writes registers
// over the APB port only while the unit is idle, which it does not enforce.
// Work: a molecule needs one square root and, unless its length is zero, three
// divides, the divider giving one quotient bit per cycle. The pair pass visits
// molecule rows and columns, and each qualifying pair costs up to five divider
// runs and one square root. One item is worked at a time.
// Reset: registers take their defaults, the frame is empty, the pair total
// and every histogram bin read as zero; no clearing pass is needed.
// Stalls: a finished result waits in the output register; the unit takes the
// next item meanwhile and only holds when a second result is ready.
`timescale 1ns / 1ps
module bilayer_splay_histogram_unit #(
  parameter int MAX_MOLECULES = 1024,
  parameter int MAX_HALF_BINS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bsh_in_if.sink                     mol_i,
  bsh_out_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsh_pkg::CFG_AW-1:0] paddr,
  input  logic [bsh_pkg::APB_DW-1:0] pwdata,
  output logic [bsh_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import bsh_pkg::*;

  localparam int AW    = $clog2(MAX_MOLECULES);
  localparam int CNTW  = $clog2(MAX_MOLECULES + 1);
  localparam int NBINS = 2 * MAX_HALF_BINS + 1;
  localparam int HAW   = $clog2(NBINS);
  localparam int HBW   = $clog2(MAX_HALF_BINS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MOL_SQ, S_MOL_SQRTW, S_MOL_DIV, S_MOL_DIVW, S_MOL_WR,
    S_PAIR_INIT, S_RDI, S_LDI, S_NEXTI, S_RDJ, S_LDJ, S_W_D, S_W_CHK, S_W_DIVW,
    S_W_MUL, S_W_SUB, S_W_SQ, S_P_SQRTW, S_P_RBW, S_S_DIV, S_S_DIVW, S_H_RD,
    S_H_WR, S_S_NEXT, S_NEXTJ, S_RESULT, S_BIN_RD, S_BIN_OUT
  } st_e;

  cfg_t cfg;

  bsh_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  st_e               state_q;
  in_item_t          item_q;
  diff_t             ox_q, oy_q, oz_q, d_q, dw_q, sel_o, sq_src;
  ori_t              orx_q, ory_q, orz_q;
  logic [1:0]        k_q;
  logic [SQ_W-1:0]   acc_q;
  logic signed [PROD_W-1:0] sq_prod, prod_q;
  logic [ROOT_W-1:0] len_q;
  logic [CNTW-1:0]   cnt_q, i_q, j_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  total_q;
  mol_rec_t          ri_q, rj_q, mol_rdata_q, mol_wrec;
  logic signed [KQ_W-1:0] kq_q;
  logic [DIST_W-1:0] r_q;
  logic [2*DIST_W-1:0] rbw_q;
  logic [HAW-1:0]    hidx_q, hist_raddr;
  logic [NBINS-1:0]  hvalid_q;
  logic [CNT_W-1:0]  hist_rdata_q, hist_old, bin_val;
  div_t              div_num_q, div_quo, qmag;
  udiv_t             div_den_q;
  logic              div_start_q, div_done, sq_start_q, sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic              out_valid_q, out_kind_q, out_drop_q, slot_free;
  logic [CNT_W-1:0]  out_count_q;

  axis_t             ax, p1, p2, spl_ax;
  logic [23:0]       box_len, bw;
  logic signed [24:0] box_s;
  logic [HBW-1:0]    hb;
  logic              tilt_rd, bin_ok;
  logic              mol_we, mol_re, hist_we, hist_re;
  logic [AW-1:0]     mol_raddr;

  mol_rec_t mol_mem [MAX_MOLECULES];
  logic [CNT_W-1:0] hist_mem [NBINS];

  bsh_div u_div (
    .clk_i, .rst_ni, .start_i (div_start_q), .num_i (div_num_q), .den_i (div_den_q),
    .done_o (div_done), .quo_o (div_quo)
  );

  bsh_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i (sq_start_q), .val_i (acc_q),
    .done_o (sq_done), .root_o (sq_root)
  );

  assign ax      = (cfg.normal_axis == 2'd3) ? AX_Z : cfg.normal_axis;
  assign p1      = next_axis(ax);
  assign p2      = next_axis(p1);
  assign spl_ax  = (k_q == 2'd0) ? p1 : p2;
  assign box_len = pick_box(cfg, k_q);
  assign box_s   = $signed({1'b0, box_len});
  assign bw      = (cfg.bin_width == 24'd0) ? 24'd1 : cfg.bin_width;
  assign hb      = (32'(cfg.half_bins) > 32'(MAX_HALF_BINS)) ? HBW'(MAX_HALF_BINS)
                                                           : HBW'(cfg.half_bins);
  assign tilt_rd = abs_ori(pick_o(mol_rdata_q, ax)) >= ORI_W'(cfg.tilt_threshold);
  assign qmag    = div_quo[DIV_W-1] ? -div_quo : div_quo;

  always_comb begin
    unique case (k_q)
      2'd0:    sel_o = ox_q;
      2'd1:    sel_o = oy_q;
      default: sel_o = oz_q;
    endcase
  end

  assign sq_src  = (state_q == S_MOL_SQ) ? sel_o : dw_q;
  assign sq_prod = sq_src * sq_src;

  assign mol_wrec = '{hx: item_q.head_x, hy: item_q.head_y, hz: item_q.head_z,
                      ox: orx_q, oy: ory_q, oz: orz_q};
  assign mol_we    = (state_q == S_MOL_WR);
  assign mol_re    = (state_q == S_RDI) || (state_q == S_RDJ);
  assign mol_raddr = (state_q == S_RDI) ? i_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mol_we) mol_mem[cnt_q[AW-1:0]] <= mol_wrec;
    if (mol_re) mol_rdata_q <= mol_mem[mol_raddr];
  end

  assign hist_we    = (state_q == S_H_WR);
  assign hist_re    = (state_q == S_H_RD) || (state_q == S_BIN_RD);
  assign hist_raddr = (state_q == S_BIN_RD) ? HAW'(item_q.bin_index) : hidx_q;
  assign hist_old   = hvalid_q[hidx_q] ? hist_rdata_q : '0;
  assign bin_ok     = 32'(item_q.bin_index) < 32'(NBINS);
  assign bin_val    = (bin_ok && hvalid_q[HAW'(item_q.bin_index)]) ? hist_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hidx_q] <= sat_inc(hist_old);
    if (hist_re) hist_rdata_q <= hist_mem[hist_raddr];
  end

  assign slot_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      hvalid_q    <= '0;
      out_valid_q <= 1'b0;
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      sq_start_q  <= 1'b0;
      if (out_valid_q && res_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (mol_i.valid) begin
            item_q <= '{op: mol_i.op, frame_end: mol_i.frame_end,
                        head_x: mol_i.head_x, head_y: mol_i.head_y, head_z: mol_i.head_z,
                        tail_x: mol_i.tail_x, tail_y: mol_i.tail_y, tail_z: mol_i.tail_z,
                        bin_index: mol_i.bin_index};
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          ox_q  <= diff_t'(item_q.head_x) - diff_t'(item_q.tail_x);
          oy_q  <= diff_t'(item_q.head_y) - diff_t'(item_q.tail_y);
          oz_q  <= diff_t'(item_q.head_z) - diff_t'(item_q.tail_z);
          acc_q <= '0;
          k_q   <= 2'd0;
          priority case (item_q.op)
            OP_MOLECULE: begin
              if (cnt_q < CNTW'(MAX_MOLECULES)) begin
                state_q <= S_MOL_SQ;
              end else begin
                ovf_q   <= 1'b1;
                state_q <= item_q.frame_end ? S_PAIR_INIT : S_IDLE;
              end
            end
            OP_READ_BIN: state_q <= S_BIN_RD;
            OP_CLEAR: begin
              hvalid_q <= '0;
              state_q  <= S_IDLE;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_MOL_SQ: begin
          acc_q <= acc_q + $unsigned(sq_prod);
          if (k_q == 2'd2) begin
            sq_start_q <= 1'b1;
            state_q    <= S_MOL_SQRTW;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        S_MOL_SQRTW: begin
          if (sq_done) begin
            len_q <= sq_root;
            k_q   <= 2'd0;
            if (sq_root == '0) begin
              orx_q   <= (ax == AX_X) ? ORI_W'(ONE_Q16) : '0;
              ory_q   <= (ax == AX_Y) ? ORI_W'(ONE_Q16) : '0;
              orz_q   <= (ax == AX_Z) ? ORI_W'(ONE_Q16) : '0;
              state_q <= S_MOL_WR;
            end else begin
              state_q <= S_MOL_DIV;
            end
          end
        end
        S_MOL_DIV: begin
          div_num_q   <= DIV_W'(sel_o) <<< FRAC;
          div_den_q   <= DIV_W'(len_q);
          div_start_q <= 1'b1;
          state_q     <= S_MOL_DIVW;
        end
        S_MOL_DIVW: begin
          if (div_done) begin
            unique case (k_q)
              2'd0:    orx_q <= ORI_W'(div_quo);
              2'd1:    ory_q <= ORI_W'(div_quo);
              default: orz_q <= ORI_W'(div_quo);
            endcase
            if (k_q == 2'd2) begin
              state_q <= S_MOL_WR;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_MOL_DIV;
            end
          end
        end
        S_MOL_WR: begin
          cnt_q   <= cnt_q + CNTW'(1);
          state_q <= item_q.frame_end ? S_PAIR_INIT : S_IDLE;
        end
        S_PAIR_INIT: begin
          i_q     <= '0;
          state_q <= (cnt_q < CNTW'(2)) ? S_RESULT : S_RDI;
        end
        S_RDI: state_q <= S_LDI;
        S_LDI: begin
          ri_q <= mol_rdata_q;
          if (tilt_rd) begin
            j_q     <= i_q + CNTW'(1);
            state_q <= S_RDJ;
          end else begin
            state_q <= S_NEXTI;
          end
        end
        S_NEXTI: begin
          i_q     <= i_q + CNTW'(1);
          state_q <= (({1'b0, i_q} + (CNTW+1)'(2)) < {1'b0, cnt_q}) ? S_RDI : S_RESULT;
        end
        S_RDJ: state_q <= S_LDJ;
        S_LDJ: begin
          rj_q  <= mol_rdata_q;
          acc_q <= '0;
          k_q   <= 2'd0;
          state_q <= tilt_rd ? S_W_D : S_NEXTJ;
        end
        S_W_D: begin
          d_q     <= diff_t'(pick_h(rj_q, k_q)) - diff_t'(pick_h(ri_q, k_q));
          state_q <= S_W_CHK;
        end
        S_W_CHK: begin
          if (box_len == 24'd0) begin
            dw_q    <= d_q;
            state_q <= S_W_SQ;
          end else begin
            div_num_q   <= DIV_W'(d_q);
            div_den_q   <= DIV_W'(box_len);
            div_start_q <= 1'b1;
            state_q     <= S_W_DIVW;
          end
        end
        S_W_DIVW: begin
          if (div_done) begin
            kq_q    <= KQ_W'(div_quo);
            state_q <= S_W_MUL;
          end
        end
        S_W_MUL: begin
          prod_q  <= kq_q * box_s;
          state_q <= S_W_SUB;
        end
        S_W_SUB: begin
          dw_q    <= DIFF_W'(d_q - prod_q);
          state_q <= S_W_SQ;
        end
        S_W_SQ: begin
          acc_q <= acc_q + $unsigned(sq_prod);
          if (k_q == 2'd2) begin
            sq_start_q <= 1'b1;
            state_q    <= S_P_SQRTW;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= S_W_D;
          end
        end
        S_P_SQRTW: begin
          if (sq_done) begin
            r_q <= DIST_W'(sq_root);
            if (sq_root == '0 || sq_root > ROOT_W'(cfg.max_pair_distance)) begin
              state_q <= S_NEXTJ;
            end else begin
              state_q <= S_P_RBW;
            end
          end
        end
        S_P_RBW: begin
          rbw_q   <= r_q * bw;
          k_q     <= 2'd0;
          state_q <= S_S_DIV;
        end
        S_S_DIV: begin
          div_num_q   <= DIV_W'(SPL_W'(pick_o(rj_q, spl_ax)) - SPL_W'(pick_o(ri_q, spl_ax)))
                         <<< FRAC;
          div_den_q   <= DIV_W'(rbw_q);
          div_start_q <= 1'b1;
          state_q     <= S_S_DIVW;
        end
        S_S_DIVW: begin
          if (div_done) begin
            hidx_q  <= HAW'(hb) + HAW'(div_quo);
            state_q <= (qmag <= DIV_W'(hb)) ? S_H_RD : S_S_NEXT;
          end
        end
        S_H_RD: state_q <= S_H_WR;
        S_H_WR: begin
          hvalid_q[hidx_q] <= 1'b1;
          state_q          <= S_S_NEXT;
        end
        S_S_NEXT: begin
          if (k_q == 2'd1) begin
            total_q <= sat_inc(total_q);
            state_q <= S_NEXTJ;
          end else begin
            k_q     <= 2'd1;
            state_q <= S_S_DIV;
          end
        end
        S_NEXTJ: begin
          j_q     <= j_q + CNTW'(1);
          state_q <= (({1'b0, j_q} + (CNTW+1)'(1)) < {1'b0, cnt_q}) ? S_RDJ : S_NEXTI;
        end
        S_RESULT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_FRAME;
            out_count_q <= total_q;
            out_drop_q  <= ovf_q;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_BIN_RD: state_q <= S_BIN_OUT;
        S_BIN_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_BIN;
            out_count_q <= bin_val;
            out_drop_q  <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mol_i.ready             = (state_q == S_IDLE);
  assign res_o.valid             = out_valid_q;
  assign res_o.result_kind       = out_kind_q;
  assign res_o.count_value       = out_count_q;
  assign res_o.molecules_dropped = out_drop_q;

endmodule

// ===== rtl/core/bsh_div.sv =====
// Iterative divider, quotient rounded half away from zero, one bit per cycle
`timescale 1ns / 1ps
module bsh_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bsh_pkg::div_t num_i,
  input  bsh_pkg::udiv_t den_i,
  output logic          done_o,
  output bsh_pkg::div_t quo_o
);
  import bsh_pkg::*;

  localparam int NW = DIV_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] nq_q, dd_q, rem_q, mag, diff;
  logic [NW:0]   rem_sh;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, neg_q, ge;

  assign mag    = num_i[DIV_W-1] ? NW'($unsigned(-num_i)) : NW'($unsigned(num_i));
  assign rem_sh = {rem_q, nq_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dd_q};
  assign diff   = NW'(rem_sh - {1'b0, dd_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        nq_q   <= (mag << 1) + NW'(den_i);
        dd_q   <= NW'(den_i) << 1;
        rem_q  <= '0;
        neg_q  <= num_i[DIV_W-1];
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff : rem_sh[NW-1:0];
        nq_q  <= {nq_q[NW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(DIV_W'(nq_q)) : $signed(DIV_W'(nq_q));

endmodule

// ===== rtl/core/bsh_sqrt.sv =====
// Iterative square root rounded to nearest, two radicand bits per cycle
`timescale 1ns / 1ps
module bsh_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bsh_pkg::SQ_W-1:0]   val_i,
  output logic                       done_o,
  output logic [bsh_pkg::ROOT_W-1:0] root_o
);
  import bsh_pkg::*;

  logic [SQ_W-1:0]   v_q, r_q, bit_q, trial;
  logic [ROOT_W-1:0] root_q;
  logic              busy_q, fin_q, done_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        v_q    <= val_i;
        r_q    <= '0;
        bit_q  <= SQ_W'(1) << (SQ_W - 2);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == SQ_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        root_q <= ROOT_W'(r_q) + ROOT_W'(v_q > r_q);
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/bsh_cfg.sv =====
// APB configuration register file
`timescale 1ns / 1ps
module bsh_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bsh_pkg::CFG_AW-1:0] paddr,
  input  logic [bsh_pkg::APB_DW-1:0] pwdata,
  output logic [bsh_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bsh_pkg::cfg_t              cfg_o
);
  import bsh_pkg::*;

  cfg_t     cfg_q;
  cfg_reg_e sel;
  logic     wr;

  assign sel    = cfg_reg_e'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_axis       <= 2'd2;
      cfg_q.max_pair_distance <= 24'd131072;
      cfg_q.tilt_threshold    <= 17'd32768;
      cfg_q.bin_width         <= 24'd3277;
      cfg_q.half_bins         <= 7'd40;
      cfg_q.box_x             <= 24'd2097152;
      cfg_q.box_y             <= 24'd2097152;
      cfg_q.box_z             <= 24'd2097152;
    end else if (wr) begin
      unique case (sel)
        REG_NORMAL_AXIS: cfg_q.normal_axis       <= pwdata[1:0];
        REG_MAX_DIST:    cfg_q.max_pair_distance <= pwdata[23:0];
        REG_TILT:        cfg_q.tilt_threshold    <= pwdata[16:0];
        REG_BIN_WIDTH:   cfg_q.bin_width         <= pwdata[23:0];
        REG_HALF_BINS:   cfg_q.half_bins         <= pwdata[6:0];
        REG_BOX_X:       cfg_q.box_x             <= pwdata[23:0];
        REG_BOX_Y:       cfg_q.box_y             <= pwdata[23:0];
        REG_BOX_Z:       cfg_q.box_z             <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_NORMAL_AXIS: prdata = APB_DW'(cfg_q.normal_axis);
      REG_MAX_DIST:    prdata = APB_DW'(cfg_q.max_pair_distance);
      REG_TILT:        prdata = APB_DW'(cfg_q.tilt_threshold);
      REG_BIN_WIDTH:   prdata = APB_DW'(cfg_q.bin_width);
      REG_HALF_BINS:   prdata = APB_DW'(cfg_q.half_bins);
      REG_BOX_X:       prdata = APB_DW'(cfg_q.box_x);
      REG_BOX_Y:       prdata = APB_DW'(cfg_q.box_y);
      REG_BOX_Z:       prdata = APB_DW'(cfg_q.box_z);
    endcase
  end

endmodule
